@@ rtl/pmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants of the proximity motion classifier
// Window sizing, calibration constants, mean divider constants and codes.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // window of offsets and differences
  localparam int WINDOW        = 10;
  localparam int CALIB_SAMPLES = 200;

  localparam int DATA_W = 16;
  localparam int CFG_W  = 15;
  localparam int OFFS_W = 17;

  // running sums over the window
  localparam int MAG_W  = $clog2(WINDOW * 32768 + 1);
  localparam int SUM_W  = MAG_W + 1;

  // divide by WINDOW through a reciprocal, exact for any MAG_W bit magnitude
  localparam int DIV_SH = MAG_W + $clog2(WINDOW);
  localparam longint DIV_M_L = ((64'd1 << DIV_SH) + WINDOW - 1) / WINDOW;
  localparam logic [MAG_W:0] DIV_M = (MAG_W + 1)'(DIV_M_L);
  localparam int PROD_W = 2 * MAG_W + 1;

  // calibration filter: level = (level * 31 + sample) / 32
  localparam int FILT_DIV = 32;
  localparam int FILT_SH  = $clog2(FILT_DIV);
  localparam int FILT_MUL = FILT_DIV - 1;
  localparam int FILT_W   = DATA_W + FILT_SH;

  localparam int CNT_W = $clog2(CALIB_SAMPLES + 2);

  localparam logic [CFG_W-1:0] HYST_RST = CFG_W'(50);
  localparam logic [CFG_W-1:0] IDLE_RST = CFG_W'(600);

  typedef enum logic [0:0] {
    REG_HYST = 1'b0,
    REG_IDLE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_RECAL  = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OFF  = 3'd0,
    ST_CAL  = 3'd1,
    ST_IDLE = 3'd2,
    ST_APPR = 3'd3,
    ST_RETR = 3'd4,
    ST_HOLD = 3'd5
  } sense_e;

  typedef enum logic [1:0] {
    PH_OFF,
    PH_CAL,
    PH_RUN
  } phase_e;

  typedef struct packed {
    logic shift;
    logic clr;
  } pmc_shift_t;

  typedef struct packed {
    logic              s_neg;
    logic [DATA_W-1:0] s_mag;
    logic              d_neg;
    logic [DATA_W-1:0] d_mag;
  } pmc_quot_t;

  // what the front stage tells the output stage about one word
  typedef struct packed {
    logic                     is_samp;
    logic                     run;
    logic                     keep_mode;
    sense_e                   mode;
    logic                     set_lvl;
    logic signed [OFFS_W-1:0] lvl;
    logic                     clr_slope;
    logic [DATA_W-1:0]        base;
  } pmc_pkt_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [OFFS_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[OFFS_W-1] != v[OFFS_W-2]) begin
      r = v[OFFS_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/pmc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_cell: one window position
// Holds one offset and one difference, takes its neighbor's pair on a shift, or zeros when clr is set.
// ----------------------------------------------------------------------------
module pmc_cell import pmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pmc_shift_t               ctl_i,
  input  logic signed [DATA_W-1:0] off_i,
  input  logic signed [DATA_W-1:0] dif_i,
  output logic signed [DATA_W-1:0] off_o,
  output logic signed [DATA_W-1:0] dif_o
);

  logic signed [DATA_W-1:0] off_q, dif_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      dif_q <= '0;
    end else if (ctl_i.shift) begin
      off_q <= ctl_i.clr ? '0 : off_i;
      dif_q <= ctl_i.clr ? '0 : dif_i;
    end
  end

  assign off_o = off_q;
  assign dif_o = dif_q;

endmodule

@@ rtl/pmc_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_window: moving window of offsets and differences
// A chain of cells with running sums kept alongside.
// ----------------------------------------------------------------------------
module pmc_window import pmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pmc_shift_t               ctl_i,
  input  logic signed [DATA_W-1:0] off_i,
  input  logic signed [DATA_W-1:0] dif_i,
  output logic signed [DATA_W-1:0] newest_o,
  output logic signed [SUM_W-1:0]  ssum_nxt_o,
  output logic signed [SUM_W-1:0]  dsum_nxt_o
);

  logic signed [DATA_W-1:0] off_w [WINDOW];
  logic signed [DATA_W-1:0] dif_w [WINDOW];
  logic signed [SUM_W-1:0]  ssum_q, ssum_d, dsum_q, dsum_d;
  pmc_shift_t               head_ctl;

  // the newest entry is loaded on every shift, never cleared
  assign head_ctl.shift = ctl_i.shift;
  assign head_ctl.clr   = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      pmc_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctl_i (head_ctl),
        .off_i (off_i),
        .dif_i (dif_i),
        .off_o (off_w[i]),
        .dif_o (dif_w[i])
      );
    end else begin : g_body
      pmc_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctl_i (ctl_i),
        .off_i (off_w[i-1]),
        .dif_i (dif_w[i-1]),
        .off_o (off_w[i]),
        .dif_o (dif_w[i])
      );
    end
  end

  always_comb begin
    ssum_d = ssum_q;
    dsum_d = dsum_q;
    if (ctl_i.shift) begin
      if (ctl_i.clr) begin
        ssum_d = SUM_W'(off_i);
        dsum_d = SUM_W'(dif_i);
      end else begin
        ssum_d = ssum_q + SUM_W'(off_i) - SUM_W'(off_w[WINDOW-1]);
        dsum_d = dsum_q + SUM_W'(dif_i) - SUM_W'(dif_w[WINDOW-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssum_q <= '0;
      dsum_q <= '0;
    end else begin
      ssum_q <= ssum_d;
      dsum_q <= dsum_d;
    end
  end

  assign newest_o   = off_w[0];
  assign ssum_nxt_o = ssum_d;
  assign dsum_nxt_o = dsum_d;

endmodule

@@ rtl/pmc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_div: window mean stage
// Magnitudes of both window sums divided by WINDOW with a reciprocal multiply.
// ----------------------------------------------------------------------------
module pmc_div import pmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SUM_W-1:0] ssum_i,
  input  logic signed [SUM_W-1:0] dsum_i,
  output pmc_quot_t               quot_o
);

  logic [MAG_W-1:0]  smag, dmag;
  logic [PROD_W-1:0] sprod, dprod;
  pmc_quot_t         quot_d, quot_q;

  always_comb begin
    smag  = ssum_i[SUM_W-1] ? MAG_W'(-ssum_i) : MAG_W'(ssum_i);
    dmag  = dsum_i[SUM_W-1] ? MAG_W'(-dsum_i) : MAG_W'(dsum_i);
    sprod = PROD_W'(smag) * PROD_W'(DIV_M);
    dprod = PROD_W'(dmag) * PROD_W'(DIV_M);
    quot_d.s_neg = ssum_i[SUM_W-1];
    quot_d.s_mag = sprod[DIV_SH +: DATA_W];
    quot_d.d_neg = dsum_i[SUM_W-1];
    quot_d.d_mag = dprod[DIV_SH +: DATA_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

@@ rtl/proximity_motion_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_motion_classifier: proximity sensor motion classifier
// Calibrates a baseline, then classifies window means into idle, approach, retract and hold.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid_i / in_stall_o) takes one word per cycle unless
//    stalled: an opcode (sample, begin, recalibrate, stop) and a raw sample
//  - every input word gives exactly one output word (out_valid_o /
//    out_stall_i) carrying the state, a changed flag, both means and the
//    baseline in force after that word
//  - the input word passes the stage a, stage b (window means) and output
//    stage registers before it is shown on the output
//  - throughput: one word per cycle while the output is not stalled; the cell
//    chain with its running sums takes a new sample every cycle, and the mean
//    multiply has a stage of its own
//  - a stalled output word holds; the three stage pipeline keeps taking
//    input until it is full, then raises in_stall_o
//  - reset clears the window, baseline and state to off, hysteresis to 50
//    and idle threshold to 600
//  - configuration writes (cfg_we_i) are meant for an idle block
// ----------------------------------------------------------------------------
module proximity_motion_classifier import pmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic [DATA_W-1:0]        sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               sense_state_o,
  output logic                     changed_o,
  output logic signed [OFFS_W-1:0] mean_offset_o,
  output logic signed [DATA_W-1:0] mean_slope_o,
  output logic [DATA_W-1:0]        baseline_out_o
);

  // configuration
  logic [CFG_W-1:0] hyst_q, idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q <= HYST_RST;
      idle_q <= IDLE_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HYST: hyst_q <= cfg_data_i;
        REG_IDLE: idle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow
  logic a_v_q, b_v_q, out_v_q;
  logic out_en, b_rdy, a_rdy, accept, a_move;

  assign out_en     = !out_v_q || !out_stall_i;
  assign b_rdy      = !b_v_q || out_en;
  assign a_rdy      = !a_v_q || b_rdy;
  assign accept     = in_valid_i && a_rdy;
  assign a_move     = a_v_q && b_rdy;
  assign in_stall_o = !a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= accept;
      if (b_rdy) b_v_q <= a_v_q;
      if (out_en) out_v_q <= b_v_q;
    end
  end

  // front stage: phase control, calibration and window update
  phase_e                   phase_q, phase_d;
  logic                     pend_q, pend_d;
  logic [DATA_W-1:0]        base_q, base_d;
  logic [DATA_W-1:0]        cal_q, cal_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [FILT_W-1:0]        filt_acc;
  logic [DATA_W-1:0]        filt;
  logic signed [DATA_W-1:0] newest, off_new, dif_new;
  logic signed [SUM_W-1:0]  ssum_nxt, dsum_nxt;
  pmc_shift_t               win_ctl;
  pmc_pkt_t                 pkt;

  assign filt_acc = FILT_W'(cal_q) * FILT_W'(FILT_MUL) + FILT_W'(sample_i);
  assign filt     = filt_acc[FILT_SH +: DATA_W];
  assign off_new  = sat16($signed({1'b0, sample_i}) - $signed({1'b0, base_q}));
  assign dif_new  = sat16(OFFS_W'(off_new) - OFFS_W'(newest));

  always_comb begin
    phase_d     = phase_q;
    pend_d      = pend_q;
    base_d      = base_q;
    cal_d       = cal_q;
    cnt_d       = cnt_q;
    win_ctl     = '0;
    pkt         = '0;
    pkt.mode    = ST_OFF;
    if (accept) begin
      case (op_e'(opcode_i))
        OP_BEGIN: begin
          base_d        = '0;
          pend_d        = 1'b1;
          pkt.keep_mode = 1'b1;
        end
        OP_RECAL: begin
          phase_d = PH_OFF;
          pend_d  = 1'b1;
        end
        OP_STOP: begin
          phase_d = PH_OFF;
        end
        OP_SAMPLE: begin
          pkt.is_samp   = 1'b1;
          win_ctl.shift = 1'b1;
          case (phase_q)
            PH_OFF: begin
              win_ctl.clr = 1'b1;
              pkt.set_lvl = 1'b1;
              pkt.lvl     = $signed({1'b0, sample_i});
              cal_d       = sample_i;
              cnt_d       = '0;
              base_d      = '0;
              if (pend_q) begin
                phase_d  = PH_CAL;
                pend_d   = 1'b0;
                pkt.mode = ST_CAL;
              end
            end
            PH_CAL: begin
              pkt.set_lvl = 1'b1;
              if (cnt_q > CNT_W'(CALIB_SAMPLES)) begin
                cnt_d         = '0;
                phase_d       = PH_RUN;
                base_d        = filt;
                pkt.lvl       = '0;
                pkt.clr_slope = 1'b1;
                pkt.mode      = ST_IDLE;
              end else begin
                cnt_d    = cnt_q + 1'b1;
                cal_d    = filt;
                pkt.lvl  = $signed({1'b0, filt});
                pkt.mode = ST_CAL;
              end
            end
            PH_RUN: begin
              pkt.run = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    pkt.base = base_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OFF;
      pend_q  <= 1'b0;
      base_q  <= '0;
      cal_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      base_q  <= base_d;
      cal_q   <= cal_d;
      cnt_q   <= cnt_d;
    end
  end

  pmc_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (win_ctl),
    .off_i     (off_new),
    .dif_i     (dif_new),
    .newest_o  (newest),
    .ssum_nxt_o(ssum_nxt),
    .dsum_nxt_o(dsum_nxt)
  );

  // stage a: word and sums after the update
  pmc_pkt_t                a_pkt_q, b_pkt_q;
  logic signed [SUM_W-1:0] a_ssum_q, a_dsum_q;
  pmc_quot_t               quot;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pkt_q  <= pkt;
      a_ssum_q <= ssum_nxt;
      a_dsum_q <= dsum_nxt;
    end
    if (a_move) begin
      b_pkt_q <= a_pkt_q;
    end
  end

  // stage b: window means
  pmc_div u_div (
    .clk_i (clk_i),
    .en_i  (a_move),
    .ssum_i(a_ssum_q),
    .dsum_i(a_dsum_q),
    .quot_o(quot)
  );

  // output stage: classification and the visible state
  sense_e                   mode_q, mode_d, run_mode;
  logic signed [OFFS_W-1:0] lvl_q, lvl_d, mean_s;
  logic signed [DATA_W-1:0] slope_q, slope_d, mean_d;
  logic                     chg_q;
  logic [DATA_W-1:0]        base_out_q;
  logic                     c_load;

  assign c_load = b_v_q && out_en;

  always_comb begin
    mean_s = quot.s_neg ? -$signed({1'b0, quot.s_mag}) : $signed({1'b0, quot.s_mag});
    mean_d = quot.d_neg ? -$signed(quot.d_mag) : $signed(quot.d_mag);
    // truncation toward zero keeps |mean| equal to the quotient magnitude
    if (quot.s_mag < {1'b0, idle_q}) begin
      run_mode = ST_IDLE;
    end else if (quot.d_mag > {1'b0, hyst_q}) begin
      run_mode = quot.d_neg ? ST_RETR : ST_APPR;
    end else begin
      run_mode = ST_HOLD;
    end

    mode_d  = mode_q;
    lvl_d   = lvl_q;
    slope_d = slope_q;
    if (b_pkt_q.run) begin
      mode_d  = run_mode;
      lvl_d   = mean_s;
      slope_d = mean_d;
    end else begin
      if (!b_pkt_q.keep_mode) mode_d = b_pkt_q.mode;
      if (b_pkt_q.set_lvl) lvl_d = b_pkt_q.lvl;
      if (b_pkt_q.clr_slope) slope_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ST_OFF;
      lvl_q      <= '0;
      slope_q    <= '0;
      chg_q      <= 1'b0;
      base_out_q <= '0;
    end else if (c_load) begin
      mode_q     <= mode_d;
      lvl_q      <= lvl_d;
      slope_q    <= slope_d;
      chg_q      <= b_pkt_q.is_samp && (mode_d != mode_q);
      base_out_q <= b_pkt_q.base;
    end
  end

  assign out_valid_o    = out_v_q;
  assign sense_state_o  = mode_q;
  assign changed_o      = chg_q;
  assign mean_offset_o  = lvl_q;
  assign mean_slope_o   = slope_q;
  assign baseline_out_o = base_out_q;

endmodule

@@ rtl/pmc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmc_checker: port level checks of the classifier
// Output hold under stall and consistency of state against reported values.
// ----------------------------------------------------------------------------
module pmc_checker import pmc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [2:0]               sense_state_o,
  input logic                     changed_o,
  input logic signed [OFFS_W-1:0] mean_offset_o,
  input logic signed [DATA_W-1:0] mean_slope_o,
  input logic [DATA_W-1:0]        baseline_out_o
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sense_state_o) &&
      $stable(changed_o) && $stable(mean_offset_o) && $stable(mean_slope_o) &&
      $stable(baseline_out_o))
    else $error("output word changed while stalled");

  // approach is only ever entered with a rising mean difference
  a_appr_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sense_state_o == ST_APPR |-> mean_slope_o > 0)
    else $error("approach reported with non-positive slope");

  a_retr_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sense_state_o == ST_RETR |-> mean_slope_o < 0)
    else $error("retract reported with non-negative slope");

  // calibration runs on raw level with the baseline cleared
  a_cal_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sense_state_o == ST_CAL |->
      baseline_out_o == '0 && mean_offset_o >= 0)
    else $error("calibration word with baseline set or negative level");

endmodule

bind proximity_motion_classifier pmc_checker u_pmc_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the proximity motion classifier
// Sends commands and sensor words through the valid/stall input channel.
// A behavioral predictor in this file works out each output word, and a
// checker compares every output word in order. Random gaps and stalls run
// on both sides, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import pmc_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 700;
  localparam int SETTLE_CYCLES = 4;
  localparam int DEF_HYST      = 50;
  localparam int DEF_IDLE      = 600;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    sense_e                   state;
    logic                     changed;
    logic signed [OFFS_W-1:0] offs;
    logic signed [DATA_W-1:0] slope;
    logic [DATA_W-1:0]        base;
  } motion_word_t;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_we_i   = 1'b0;
  logic                     cfg_idx_i  = 1'b0;
  logic [CFG_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               opcode_i   = 2'b00;
  logic [DATA_W-1:0]        sample_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [2:0]               sense_state_o;
  logic                     changed_o;
  logic signed [OFFS_W-1:0] mean_offset_o;
  logic signed [DATA_W-1:0] mean_slope_o;
  logic [DATA_W-1:0]        baseline_out_o;

  // predictor state
  int               sample_win [WINDOW];
  int               diff_win [WINDOW];
  sense_e           cur_mode;
  bit               start_pend;
  logic [DATA_W-1:0] base_reg;
  int               level_acc;
  int               slope_acc;
  int               cal_cnt;
  logic [CFG_W-1:0] hyst_cfg;
  logic [CFG_W-1:0] idle_cfg;

  motion_word_t pending_results[$];

  int err_count     = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int changes_seen  = 0;
  int state_hits [6];
  int quiet_cycles  = 0;
  bit no_idle       = 1'b0;
  int hold_off_left = 0;
  int stall_left    = 0;

  proximity_motion_classifier u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sense_state_o  (sense_state_o),
    .changed_o      (changed_o),
    .mean_offset_o  (mean_offset_o),
    .mean_slope_o   (mean_slope_o),
    .baseline_out_o (baseline_out_o)
  );

  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk_i = ~clk_i;
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic int jitter(int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(7, 40);
  endfunction

  function automatic void reset_predictor();
    int i;
    for (i = 0; i < WINDOW; i++) begin
      sample_win[i] = 0;
      diff_win[i]   = 0;
    end
    cur_mode   = ST_OFF;
    start_pend = 1'b0;
    base_reg   = '0;
    level_acc  = 0;
    slope_acc  = 0;
    cal_cnt    = 0;
    hyst_cfg   = CFG_W'(DEF_HYST);
    idle_cfg   = CFG_W'(DEF_IDLE);
    for (i = 0; i < 6; i++) state_hits[i] = 0;
  endfunction

  // advances the predictor by one word and returns the output word it gives
  function automatic motion_word_t classify_word(op_e op, logic [DATA_W-1:0] raw);
    motion_word_t r;
    sense_e       prior;
    int           offs;
    int           dif;
    int           s_sum;
    int           d_sum;
    int           mag;
    int           i;
    prior = cur_mode;
    case (op)
      OP_BEGIN: begin
        base_reg   = '0;
        start_pend = 1'b1;
      end
      OP_RECAL: begin
        cur_mode   = ST_OFF;
        start_pend = 1'b1;
      end
      OP_STOP: begin
        cur_mode = ST_OFF;
      end
      default: begin
        offs = clamp(int'(raw) - int'(base_reg), -32768, 32767);
        dif  = clamp(offs - sample_win[0], -32768, 32767);
        for (i = WINDOW - 1; i > 0; i--) begin
          sample_win[i] = sample_win[i-1];
          diff_win[i]   = diff_win[i-1];
        end
        sample_win[0] = offs;
        diff_win[0]   = dif;
        if (cur_mode == ST_OFF) begin
          for (i = 1; i < WINDOW; i++) begin
            sample_win[i] = 0;
            diff_win[i]   = 0;
          end
          level_acc = int'(raw);
          if (start_pend) begin
            cur_mode   = ST_CAL;
            start_pend = 1'b0;
          end
          cal_cnt  = 0;
          base_reg = '0;
        end else if (cur_mode == ST_CAL) begin
          level_acc = int'((longint'(level_acc) * FILT_MUL + longint'(raw)) / FILT_DIV);
          if (cal_cnt > CALIB_SAMPLES) begin
            cal_cnt   = 0;
            cur_mode  = ST_IDLE;
            base_reg  = level_acc[DATA_W-1:0];
            level_acc = 0;
            slope_acc = 0;
          end else begin
            cal_cnt++;
          end
        end else begin
          s_sum = 0;
          d_sum = 0;
          for (i = 0; i < WINDOW; i++) begin
            s_sum += sample_win[i];
            d_sum += diff_win[i];
          end
          level_acc = s_sum / WINDOW;
          slope_acc = d_sum / WINDOW;
          mag = (level_acc < 0) ? -level_acc : level_acc;
          if (mag < int'(idle_cfg)) cur_mode = ST_IDLE;
          else if (slope_acc > int'(hyst_cfg)) cur_mode = ST_APPR;
          else if (slope_acc < -int'(hyst_cfg)) cur_mode = ST_RETR;
          else cur_mode = ST_HOLD;
        end
      end
    endcase
    r.state   = cur_mode;
    r.changed = (op == OP_SAMPLE) && (cur_mode != prior);
    r.offs    = level_acc[OFFS_W-1:0];
    r.slope   = slope_acc[DATA_W-1:0];
    r.base    = base_reg;
    return r;
  endfunction

  task automatic send_word(op_e op, logic [DATA_W-1:0] raw);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    sample_i   <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(classify_word(op, raw));
    words_sent++;
    gap = 0;
    if (!no_idle && $urandom_range(0, 9) < 4) gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // let the pipeline empty before touching the registers
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HYST) hyst_cfg = val;
    else idle_cfg = val;
  endtask

  // recalibrate, then feed exactly enough words to reach the running phase
  task automatic calibrate(int level, int noise);
    send_word(OP_RECAL, 16'($urandom));
    repeat (CALIB_SAMPLES + 3) begin
      send_word(OP_SAMPLE, 16'(clamp(level + jitter(noise), 0, 65535)));
    end
  endtask

  // ramp of offsets around the current baseline
  task automatic drive_motion(int start, int step, int len, int noise);
    int k;
    int pos;
    for (k = 0; k < len; k++) begin
      pos = start + step * k + jitter(noise);
      send_word(OP_SAMPLE, 16'(clamp(int'(base_reg) + pos, 0, 65535)));
    end
  endtask

  function automatic int rand_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 300);
    if (r < 20) return 65535 - int'($urandom_range(0, 300));
    return $urandom_range(1000, 64000);
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg(int typical);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 36) return CFG_W'($urandom);
    return CFG_W'($urandom_range(0, typical));
  endfunction

  task automatic test_off_commands();
    send_word(OP_SAMPLE, 16'h0000);
    send_word(OP_SAMPLE, 16'hFFFF);   // offset clips at the top
    send_word(OP_SAMPLE, 16'h0000);
    send_word(OP_STOP,   16'h1234);
    send_word(OP_SAMPLE, 16'h5555);   // off with nothing pending
    send_word(OP_BEGIN,  16'hAAAA);
    send_word(OP_RECAL,  16'h0000);
    send_word(OP_SAMPLE, 16'h8000);   // enters calibration
    send_word(OP_BEGIN,  16'h0000);   // begin while calibrating
    send_word(OP_SAMPLE, 16'h7FFF);
    send_word(OP_STOP,   16'h0000);
    send_word(OP_SAMPLE, 16'h0001);
    send_word(OP_STOP,   16'hFFFF);
  endtask

  task automatic test_calibration_extremes();
    calibrate(65535, 0);
    // offsets clip at the bottom with a full scale baseline
    send_word(OP_SAMPLE, 16'h0000);
    send_word(OP_SAMPLE, 16'h0000);
    send_word(OP_SAMPLE, 16'h0000);
    send_word(OP_BEGIN,  16'h0000);   // baseline drops to zero while running
    send_word(OP_SAMPLE, 16'hFFFF);   // difference clips at the top
    send_word(OP_SAMPLE, 16'h0000);
    send_word(OP_STOP,   16'h0000);
    send_word(OP_SAMPLE, 16'h0064);
    calibrate(0, 0);
    drive_motion(0, 6000, 12, 0);
    drive_motion(65535, -6000, 12, 0);
  endtask

  task automatic test_threshold_extremes();
    int               k;
    logic [CFG_W-1:0] hyst_set [5];
    logic [CFG_W-1:0] idle_set [5];
    hyst_set = '{15'd0, 15'h7FFF, 15'd0, 15'h7FFF, 15'(DEF_HYST)};
    idle_set = '{15'd0, 15'h7FFF, 15'h7FFF, 15'd0, 15'(DEF_IDLE)};
    calibrate(30000, 40);
    for (k = 0; k < 5; k++) begin
      quiesce();
      write_reg(REG_HYST, hyst_set[k]);
      write_reg(REG_IDLE, idle_set[k]);
      drive_motion(9000, 1200, 12, 30);
      drive_motion(-9000, -1200, 12, 30);
      drive_motion(20000, 0, 12, 0);
      drive_motion(0, 0, 12, 20);
      drive_motion(40000, 0, 10, 0);
    end
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_off_left = 300;
    drive_motion(5000, 800, 40, 100);
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int first;
    int pick;
    int lvl;
    int k;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        quiesce();
        write_reg(REG_HYST, rand_cfg(3000));
        write_reg(REG_IDLE, rand_cfg(4000));
      end else if (pick < 15 ||
                   ((cur_mode == ST_OFF || cur_mode == ST_CAL) && pick < 60)) begin
        calibrate(rand_level(), $urandom_range(0, 400));
      end else if (pick < 22) begin
        // calibration cut short
        lvl = rand_level();
        send_word($urandom_range(0, 1) ? OP_RECAL : OP_BEGIN, 16'($urandom));
        repeat ($urandom_range(1, 150)) begin
          send_word(OP_SAMPLE, 16'(clamp(lvl + jitter(300), 0, 65535)));
        end
        send_word(op_e'($urandom_range(1, 3)), 16'($urandom));
      end else if (pick < 32) begin
        repeat ($urandom_range(1, 8)) begin
          send_word(op_e'($urandom_range(0, 3)), 16'($urandom));
        end
      end else if (pick < 47) begin
        drive_motion(jitter(800), 0, $urandom_range(5, 20), $urandom_range(0, 200));
      end else begin
        k = $urandom_range(0, 1) ? jitter(400) : jitter(4000);
        drive_motion(jitter(25000), k, $urandom_range(5, 40), $urandom_range(0, 300));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic flag_mismatch(string field, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (err_count < MAX_REPORTS) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
    err_count++;
  endtask

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = gap_len() - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    motion_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (sense_state_o <= ST_HOLD) state_hits[sense_state_o]++;
      if (changed_o) changes_seen++;
      if (pending_results.size() == 0) begin
        if (err_count < MAX_REPORTS) begin
          $display("%0t ns: output word with none expected, expected none, got state %0d",
                   $time, sense_state_o);
        end
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (sense_state_o !== want.state)
          flag_mismatch("sense_state", want.state, sense_state_o);
        if (changed_o !== want.changed)
          flag_mismatch("changed", want.changed, changed_o);
        if (mean_offset_o !== want.offs)
          flag_mismatch("mean_offset", want.offs, mean_offset_o);
        if (mean_slope_o !== want.slope)
          flag_mismatch("mean_slope", want.slope, mean_slope_o);
        if (baseline_out_o !== want.base)
          flag_mismatch("baseline_out", want.base, baseline_out_o);
      end
    end
  end

  // watchdog: ends the run once no word has moved for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t ns: watchdog, no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_off_commands();
    test_calibration_extremes();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("tb_top: %0d words sent, %0d output words checked, %0d state changes",
             words_sent, results_seen, changes_seen);
    $display("tb_top: off %0d, calibrating %0d, idle %0d, approach %0d, retract %0d, hold %0d",
             state_hits[ST_OFF], state_hits[ST_CAL], state_hits[ST_IDLE],
             state_hits[ST_APPR], state_hits[ST_RETR], state_hits[ST_HOLD]);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
